/* rtl/tsdz_pkg.sv */
// Shared types and constants of the thumbstick dead zone block.
`default_nettype none
package tsdz_pkg;

    // Result magnitude bits; full output is all ones in this width.
    localparam int QUOT_BITS = 15;
    localparam logic [QUOT_BITS-1:0] FULL_OUT = '1;

    localparam int OUT_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ZONE_MODE  = 2'd0;
    localparam cfg_index_t CFG_FULL_SCALE = 2'd1;
    localparam cfg_index_t CFG_DEAD_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        ZONE_INDEPENDENT = 2'd0,
        ZONE_CIRCULAR    = 2'd1,
        ZONE_NONE        = 2'd2
    } zone_mode_t;

    localparam logic [1:0]           ZONE_MODE_RESET  = 2'd0;
    localparam logic [CFG_DATA_BITS-1:0] FULL_SCALE_RESET = 16'd32767;
    localparam logic [CFG_DATA_BITS-1:0] DEAD_WIDTH_RESET = 16'd7864;

    // Lane flags carried beside each axis division.
    typedef struct packed {
        logic neg;
        logic zero;
        logic full;
    } lane_flags_t;

endpackage
`default_nettype wire

/* rtl/tsdz_in_if.sv */
// Request channel carrying one raw stick sample pair.
`default_nettype none
interface tsdz_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] axis_x;
    logic signed [SAMPLE_BITS-1:0] axis_y;

    modport source (output valid, output axis_x, output axis_y, input ready);
    modport sink   (input valid, input axis_x, input axis_y, output ready);
endinterface
`default_nettype wire

/* rtl/tsdz_out_if.sv */
// Request channel carrying one dead-zoned Q1.15 pair.
`default_nettype none
interface tsdz_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic signed [tsdz_pkg::OUT_BITS-1:0] shaped_x;
    logic signed [tsdz_pkg::OUT_BITS-1:0] shaped_y;

    modport source (output valid, output shaped_x, output shaped_y, input ready);
    modport sink   (input valid, input shaped_x, input shaped_y, output ready);
endinterface
`default_nettype wire

/* rtl/tsdz_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tsdz_isqrt #(
    parameter int SB = 16,
    parameter int SW = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2*SB-1:0] n,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_valid,
    output logic [SB-1:0]        root,
    output logic [SW-1:0]        out_side
);
    localparam int W2 = 2 * SB;

    logic          v_reg    [0:SB];
    logic [W2-1:0] rem_reg  [0:SB];
    logic [W2-1:0] res_reg  [0:SB];
    logic [SW-1:0] side_reg [0:SB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= n;
            res_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= SB; k++)
    begin : g_step
        localparam logic [W2-1:0] BIT = W2'(1) << (2 * (SB - k));
        logic [W2-1:0] trial;
        logic          take;

        assign trial = res_reg[k-1] + BIT;
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                res_reg[k]  <= take ? (res_reg[k-1] >> 1) + BIT : res_reg[k-1] >> 1;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[SB];
    assign root      = res_reg[SB][SB-1:0];
    assign out_side  = side_reg[SB];
endmodule
`default_nettype wire

/* rtl/tsdz_div.sv */
// Pipelined restoring divider with a saturating 15-bit quotient.
`default_nettype none
module tsdz_div #(
    parameter int NW = 31,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [NW-1:0]                  num,
    input  wire logic [QW-1:0]                  den,
    input  wire logic [SW-1:0]                  in_side,
    output logic                                out_valid,
    output logic [tsdz_pkg::QUOT_BITS-1:0]      quot,
    output logic [SW-1:0]                       out_side
);
    localparam int QB = tsdz_pkg::QUOT_BITS;
    localparam int CW = ((NW > QW + QB) ? NW : QW + QB) + 1;

    logic          v_reg    [0:QB];
    logic          sat_reg  [0:QB];
    logic [CW-1:0] rem_reg  [0:QB];
    logic [QW-1:0] den_reg  [0:QB];
    logic [QB-1:0] q_reg    [0:QB];
    logic [SW-1:0] side_reg [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    // A quotient that reaches 2^15 can only clamp, so it is caught up front.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]  <= CW'(num) >= (CW'(den) << QB);
            rem_reg[0]  <= CW'(num);
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        localparam int SH = QB - i;
        logic [CW-1:0] shifted;
        logic          ge;

        assign shifted = CW'(den_reg[i-1]) << SH;
        assign ge      = rem_reg[i-1] >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[i]  <= sat_reg[i-1];
                rem_reg[i]  <= ge ? rem_reg[i-1] - shifted : rem_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                q_reg[i]    <= {q_reg[i-1][QB-2:0], ge};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quot      = sat_reg[QB] ? tsdz_pkg::FULL_OUT : q_reg[QB];
    assign out_side  = side_reg[QB];
endmodule
`default_nettype wire

/* rtl/thumbstick_dead_zone.sv */
// Top level of the thumbstick dead zone: config registers and the main pipeline.
//
//   channel   modport  payload              role
//   sample    sink     axis_x, axis_y       raw stick pair in
//   shaped    source   shaped_x, shaped_y   dead-zoned Q1.15 pair out
//   cfg_*     -        index, data          register writes
//
// One request enters per cycle while the output register is not stalled; a request
// passes the root pipeline (SAMPLE_BITS + 1 stages) and two 16-stage dividers in series.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds while a result waits unaccepted at the output
// register; ready follows that hold, so nothing is dropped or repeated.
`default_nettype none
module thumbstick_dead_zone #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    tsdz_in_if.sink                                   sample,
    tsdz_out_if.source                                shaped,
    input  wire logic                                 cfg_write,
    input  wire logic [tsdz_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tsdz_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    localparam int SB = SAMPLE_BITS;
    localparam int QW = (SB > 16) ? SB : 16;
    localparam int EW = QW + 1;
    localparam int NW = SB + 15;
    localparam int QB = tsdz_pkg::QUOT_BITS;
    localparam int OB = tsdz_pkg::OUT_BITS;
    localparam int S1 = 2 * SB + 2;
    localparam int S2 = S1 + SB + 2;
    localparam int FW = $bits(tsdz_pkg::lane_flags_t);

    // Configuration registers.
    logic [1:0]  zone_mode_reg;
    logic [15:0] full_scale_reg;
    logic [15:0] dead_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_mode_reg  <= tsdz_pkg::ZONE_MODE_RESET;
            full_scale_reg <= tsdz_pkg::FULL_SCALE_RESET;
            dead_width_reg <= tsdz_pkg::DEAD_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            priority if (cfg_index == tsdz_pkg::CFG_ZONE_MODE)
                zone_mode_reg <= cfg_data[1:0];
            else if (cfg_index == tsdz_pkg::CFG_FULL_SCALE)
                full_scale_reg <= cfg_data;
            else if (cfg_index == tsdz_pkg::CFG_DEAD_WIDTH)
                dead_width_reg <= cfg_data;
        end
    end

    logic en;
    logic out_v_reg;

    assign en           = !out_v_reg || shaped.ready;
    assign sample.ready = en;

    // Input capture.
    logic                 in_v_reg;
    logic signed [SB-1:0] in_x_reg;
    logic signed [SB-1:0] in_y_reg;

    // Magnitudes and signs.
    logic          abs_v_reg;
    logic [SB-1:0] abs_mag_reg [0:1];
    logic          abs_neg_reg [0:1];
    logic [SB-1:0] abs_mag_next [0:1];

    // Squares.
    logic            sq_v_reg;
    logic [2*SB-1:0] sq_reg     [0:1];
    logic [SB-1:0]   sq_mag_reg [0:1];
    logic            sq_neg_reg [0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            abs_v_reg <= 1'b0;
            sq_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            in_v_reg  <= sample.valid;
            abs_v_reg <= in_v_reg;
            sq_v_reg  <= abs_v_reg;
        end
    end

    // The most negative sample has magnitude 2^(SB-1), which still fits SB bits.
    always_comb
    begin
        abs_mag_next[0] = in_x_reg[SB-1] ? ~in_x_reg + 1'b1 : in_x_reg;
        abs_mag_next[1] = in_y_reg[SB-1] ? ~in_y_reg + 1'b1 : in_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_x_reg <= SB'(sample.axis_x);
            in_y_reg <= SB'(sample.axis_y);
            for (int l = 0; l < 2; l++)
            begin
                abs_mag_reg[l] <= abs_mag_next[l];
                sq_reg[l]      <= (2*SB)'(abs_mag_reg[l]) * (2*SB)'(abs_mag_reg[l]);
                sq_mag_reg[l]  <= abs_mag_reg[l];
                sq_neg_reg[l]  <= abs_neg_reg[l];
            end
            abs_neg_reg[0] <= in_x_reg[SB-1];
            abs_neg_reg[1] <= in_y_reg[SB-1];
        end
    end

    // Radius.
    logic            rt_valid;
    logic [SB-1:0]   rt_root;
    logic [S1-1:0]   rt_side;

    tsdz_isqrt #(
        .SB (SB),
        .SW (S1)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v_reg),
        .n         (sq_reg[0] + sq_reg[1]),
        .in_side   ({sq_neg_reg[0], sq_neg_reg[1], sq_mag_reg[0], sq_mag_reg[1]}),
        .out_valid (rt_valid),
        .root      (rt_root),
        .out_side  (rt_side)
    );

    // Linear rule on the radius.
    logic [EW-1:0] full_e;
    logic [EW-1:0] dead_e;
    logic [EW-1:0] r_e;
    logic          rz_next;
    logic          rf_next;
    logic [NW-1:0] rdiff;
    logic          l_v_reg;
    logic [NW-1:0] l_num_reg;
    logic [QW-1:0] l_den_reg;
    logic [S2-1:0] l_side_reg;

    assign full_e  = EW'(full_scale_reg);
    assign dead_e  = EW'(dead_width_reg);
    assign r_e     = EW'(rt_root);
    assign rz_next = r_e <= dead_e;
    assign rf_next = dead_e >= full_e;
    assign rdiff   = NW'(SB'(r_e - dead_e));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_v_reg <= 1'b0;
        end
        else if (en)
        begin
            l_v_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rz_next || rf_next)
            begin
                l_num_reg <= '0;
                l_den_reg <= QW'(1);
            end
            else
            begin
                l_num_reg <= (rdiff << 15) - rdiff;
                l_den_reg <= QW'(full_e - dead_e);
            end
            l_side_reg <= {rt_side, rt_root, rz_next, rf_next};
        end
    end

    logic          wd_valid;
    logic [QB-1:0] wd_quot;
    logic [S2-1:0] wd_side;

    tsdz_div #(
        .NW (NW),
        .QW (QW),
        .SW (S2)
    ) u_div_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l_v_reg),
        .num       (l_num_reg),
        .den       (l_den_reg),
        .in_side   (l_side_reg),
        .out_valid (wd_valid),
        .quot      (wd_quot),
        .out_side  (wd_side)
    );

    // Radial weight and per-axis products.
    logic [QB-1:0] w_next;
    logic          m_v_reg;
    logic [QB-1:0] m_w_reg;
    logic [SB-1:0] m_r_reg;
    logic [NW-1:0] m_prod_reg [0:1];
    logic [SB-1:0] m_mag_reg  [0:1];
    logic          m_neg_reg  [0:1];

    assign w_next = wd_side[1] ? '0 : (wd_side[0] ? tsdz_pkg::FULL_OUT : wd_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_w_reg       <= w_next;
            m_r_reg       <= wd_side[SB+1:2];
            m_neg_reg[0]  <= wd_side[S2-1];
            m_neg_reg[1]  <= wd_side[S2-2];
            m_mag_reg[0]  <= wd_side[S2-3 -: SB];
            m_mag_reg[1]  <= wd_side[SB+2 +: SB];
            m_prod_reg[0] <= NW'(wd_side[S2-3 -: SB]) * NW'(w_next);
            m_prod_reg[1] <= NW'(wd_side[SB+2 +: SB]) * NW'(w_next);
        end
    end

    // Per-axis numerator and divisor by mode.
    logic                 p_v_reg;
    logic [NW-1:0]        p_num_reg  [0:1];
    logic [QW-1:0]        p_den_reg  [0:1];
    tsdz_pkg::lane_flags_t p_flag_reg [0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= m_v_reg;
        end
    end

    logic          dv_valid [0:1];
    logic [QB-1:0] dv_quot  [0:1];
    logic [FW-1:0] dv_side  [0:1];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [EW-1:0] dd;
        logic [NW-1:0] ldiff;
        logic          zero;
        logic          full;
        logic [NW-1:0] num;
        logic [QW-1:0] den;

        always_comb
        begin
            dd    = (zone_mode_reg == tsdz_pkg::ZONE_INDEPENDENT) ? dead_e : '0;
            ldiff = NW'(SB'(EW'(m_mag_reg[l]) - dd));
            if (zone_mode_reg == tsdz_pkg::ZONE_CIRCULAR)
            begin
                zero = m_w_reg == '0;
                full = 1'b0;
                num  = m_prod_reg[l];
                den  = QW'(m_r_reg);
            end
            else
            begin
                zero = EW'(m_mag_reg[l]) <= dd;
                full = dd >= full_e;
                num  = (ldiff << 15) - ldiff;
                den  = QW'(full_e - dd);
            end
            if (zero || full)
            begin
                num = '0;
                den = QW'(1);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_num_reg[l]       <= num;
                p_den_reg[l]       <= den;
                p_flag_reg[l].neg  <= m_neg_reg[l];
                p_flag_reg[l].zero <= zero;
                p_flag_reg[l].full <= full;
            end
        end

        tsdz_div #(
            .NW (NW),
            .QW (QW),
            .SW (FW)
        ) u_div_axis (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (p_v_reg),
            .num       (p_num_reg[l]),
            .den       (p_den_reg[l]),
            .in_side   (p_flag_reg[l]),
            .out_valid (dv_valid[l]),
            .quot      (dv_quot[l]),
            .out_side  (dv_side[l])
        );
    end

    // Output register with sign restored.
    tsdz_pkg::lane_flags_t fl [0:1];
    logic [OB-1:0]         mag_out [0:1];
    logic [OB-1:0]         val_out [0:1];
    logic [OB-1:0]         out_x_reg;
    logic [OB-1:0]         out_y_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            fl[l]      = dv_side[l];
            mag_out[l] = fl[l].zero ? '0
                       : (fl[l].full ? OB'(tsdz_pkg::FULL_OUT) : OB'(dv_quot[l]));
            val_out[l] = fl[l].neg ? ~mag_out[l] + 1'b1 : mag_out[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= val_out[0];
            out_y_reg <= val_out[1];
        end
    end

    assign shaped.valid    = out_v_reg;
    assign shaped.shaped_x = out_x_reg;
    assign shaped.shaped_y = out_y_reg;

`ifndef SYNTHESIS
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        shaped.valid |-> shaped.shaped_x != 16'sh8000)
        else $error("shaped_x reached the excluded most negative code");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        shaped.valid |-> shaped.shaped_y != 16'sh8000)
        else $error("shaped_y reached the excluded most negative code");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        shaped.valid && !shaped.ready |-> !sample.ready)
        else $error("input taken while the output register is blocked");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[0] == dv_valid[1])
        else $error("axis dividers out of step");
`endif
endmodule
`default_nettype wire
